/* rtl/core/nnis_pkg.sv */
// shared constants, register codes and helpers of the nearest neighbor scaler
package nnis_pkg;

	// configuration register widths
	localparam int CFG_W    = 9;
	localparam int CH_REG_W = 3;
	localparam int CFG_IDX_W = 3;

	// default size limits
	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_HEIGHT   = 256;
	localparam int DEF_MAX_CHANNELS = 4;

	// reset values of the configuration registers
	localparam int RST_DIM      = 256;
	localparam int RST_CHANNELS = 3;

	// byte and channel field widths
	localparam int BYTE_W = 8;
	localparam int CHAN_W = 2;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_CHANNELS   = 3'd4
	} cfg_reg_t;

	// item operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	// bits needed to index n entries, at least one
	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// a zero register counts as 1, a value above the limit as the limit
	function automatic int clamp_dim(input int v, input int hi);
		int r;
		r = v;
		if (v == 0) begin
			r = 1;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

/* rtl/core/nnis_ram.sv */
// generic simple dual port ram with registered read
module nnis_ram
	import nnis_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [addr_bits(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	input  logic [addr_bits(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/nnis_div.sv */
// restoring divider, one quotient bit per cycle
module nnis_div
	import nnis_pkg::*;
#(
	parameter int NW = 17,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);

	localparam int CNTW = addr_bits(NW);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   divisor_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;

	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic        fits;

	// trial subtraction of one step
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		diff    = shifted - {1'b0, divisor_q};
		fits    = !diff[DW];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(NW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNTW'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/core/nearest_neighbor_image_scaler.sv */
// nearest neighbor image scaler top level: frame store, target stepping, output stage
//
//  channel   direction  handshake         payload
//  s_*       in         s_tvalid/s_tready tdata src_byte, tuser op
//  m_*       out        m_tvalid/m_tready tdata pixel_byte, tuser channel_index, tlast frame_end
//  cfg_*     in         cfg_we            cfg_index, cfg_data
//
// a load is written as it is accepted; an emit passes through capture, row multiply, address and
// store read, and the output register, and no further item is accepted until it reaches the output register.
// after reset and after every register write a setup pass computes the frame size and runs the shared
// divider four times (step quotients, then current positions); no item is accepted meanwhile.
// a result waiting in the output register does not stop loads; a further emit waits
// in its last stage until the output register frees.
module nearest_neighbor_image_scaler
	import nnis_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] src_byte
	input  logic                 s_tuser,   // [0] op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BYTE_W-1:0]    m_tdata,   // [7:0] pixel_byte
	output logic [CHAN_W-1:0]    m_tuser,   // [1:0] channel_index
	output logic                 m_tlast,   // frame_end
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int XW    = addr_bits(MAX_WIDTH);
	localparam int YW    = addr_bits(MAX_HEIGHT);
	localparam int TCW   = addr_bits(MAX_CHANNELS);
	localparam int DWW   = addr_bits(MAX_WIDTH + 1);
	localparam int DHW   = addr_bits(MAX_HEIGHT + 1);
	localparam int CW    = addr_bits(MAX_CHANNELS + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int AW    = addr_bits(DEPTH);
	localparam int FW    = addr_bits(DEPTH + 1);
	localparam int PW    = addr_bits(MAX_WIDTH * MAX_HEIGHT);
	localparam int NW    = (YW + DHW > XW + DWW) ? (YW + DHW) : (XW + DWW);
	localparam int DVW   = (DWW > DHW) ? DWW : DHW;

	typedef enum logic [5:0] {
		ST_NORM    = 6'b000001,
		ST_FRAME   = 6'b000010,
		ST_LOAD    = 6'b000100,
		ST_DIVGO   = 6'b001000,
		ST_DIVWAIT = 6'b010000,
		ST_RUN     = 6'b100000
	} seq_state_t;

	// configuration registers
	logic [CFG_W-1:0]    src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [CH_REG_W-1:0] chan_q;

	// effective sizes
	logic [DWW-1:0] sw_eff, dw_eff;
	logic [DHW-1:0] sh_eff, dh_eff;
	logic [CW-1:0]  ch_eff;

	// sequencer and stepping state
	seq_state_t          state_q;
	logic [1:0]          div_sel_q;
	logic [DWW+DHW-1:0]  area_q;
	logic [FW-1:0]       frame_q;
	logic [AW-1:0]       load_q;
	logic [XW-1:0]       tx_q, sx_q;
	logic [YW-1:0]       ty_q, sy_q;
	logic [TCW-1:0]      tc_q;
	logic [DWW-1:0]      rx_q, rx0_q, qx0_q;
	logic [DHW-1:0]      ry_q, ry0_q, qy0_q;
	logic                restart_q;

	// target position seen by the next emit
	logic [XW-1:0]       tx_pos;
	logic [YW-1:0]       ty_pos;
	logic [TCW-1:0]      tc_pos;

	// emit pipeline
	logic                v_s1, v_s2, v_s3;
	logic [YW-1:0]       sy_s1;
	logic [XW-1:0]       sx_s1, sx_s2;
	logic [TCW-1:0]      tc_s1, tc_s2, tc_s3;
	logic                end_s1, end_s2, end_s3;
	logic [PW-1:0]       rb_s2;

	// output register
	logic                m_tvalid_q;
	logic [BYTE_W-1:0]   pixel_q;
	logic [CHAN_W-1:0]   chidx_q;
	logic                last_q;

	// divider hookup
	logic                div_start, div_done;
	logic [NW-1:0]       div_dividend, div_quo;
	logic [DVW-1:0]      div_divisor, div_rem;
	logic [YW+DHW-1:0]   ty_prod;
	logic [XW+DWW-1:0]   tx_prod;

	// misc datapath
	logic                busy, load_acc, emit_acc, out_load;
	logic                last_ch, last_col, last_row;
	logic [DWW:0]        xsum;
	logic [DHW:0]        ysum;
	logic [DWW:0]        sx_next;
	logic [DHW:0]        sy_next;
	logic [DWW+DHW+CW-1:0] frame_full;
	logic [YW+DWW-1:0]   rb_full;
	logic [PW+CW-1:0]    addr_full;
	logic [PW-1:0]       pix_s2;
	logic [AW-1:0]       rd_addr;
	logic [BYTE_W-1:0]   rd_data;
	logic [AW-1:0]       load_eff;
	logic [FW-1:0]       load_inc;

	// clamp register values to usable sizes
	always_comb begin
		sw_eff = DWW'(clamp_dim(int'(src_w_q), MAX_WIDTH));
		sh_eff = DHW'(clamp_dim(int'(src_h_q), MAX_HEIGHT));
		dw_eff = DWW'(clamp_dim(int'(dst_w_q), MAX_WIDTH));
		dh_eff = DHW'(clamp_dim(int'(dst_h_q), MAX_HEIGHT));
		ch_eff = CW'(clamp_dim(int'(chan_q), MAX_CHANNELS));
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= CFG_W'(RST_DIM);
			src_h_q <= CFG_W'(RST_DIM);
			dst_w_q <= CFG_W'(RST_DIM);
			dst_h_q <= CFG_W'(RST_DIM);
			chan_q  <= CH_REG_W'(RST_CHANNELS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_w_q <= cfg_data;
				REG_SRC_HEIGHT: src_h_q <= cfg_data;
				REG_DST_WIDTH:  dst_w_q <= cfg_data;
				REG_DST_HEIGHT: dst_h_q <= cfg_data;
				REG_CHANNELS:   chan_q  <= cfg_data[CH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign busy     = v_s1 | v_s2 | v_s3;
	assign s_tready = (state_q == ST_RUN) && !busy;
	assign load_acc = s_tvalid && s_tready && (s_tuser == OP_LOAD);
	assign emit_acc = s_tvalid && s_tready && (s_tuser == OP_EMIT);
	assign out_load = v_s3 && (!m_tvalid_q || m_tready);

	// counters left outside the frame by the registers start over at the next emit
	always_comb begin
		tx_pos = restart_q ? '0 : tx_q;
		ty_pos = restart_q ? '0 : ty_q;
		tc_pos = restart_q ? '0 : tc_q;
	end

	// position tests and incremental source stepping
	always_comb begin
		last_ch  = (CW'(tc_pos) + CW'(1)) >= ch_eff;
		last_col = (DWW'(tx_pos) + DWW'(1)) >= dw_eff;
		last_row = (DHW'(ty_pos) + DHW'(1)) >= dh_eff;
		xsum     = (DWW+1)'(rx_q) + (DWW+1)'(rx0_q);
		ysum     = (DHW+1)'(ry_q) + (DHW+1)'(ry0_q);
		sx_next  = (DWW+1)'(sx_q) + (DWW+1)'(qx0_q);
		sy_next  = (DHW+1)'(sy_q) + (DHW+1)'(qy0_q);
		frame_full = (DWW+DHW+CW)'(area_q) * (DWW+DHW+CW)'(ch_eff);
		// a load address left past the frame starts over before the write
		load_eff = (FW'(load_q) >= frame_q) ? '0 : load_q;
		load_inc = FW'(load_eff) + FW'(1);
	end

	// divider operand select: step quotients first, then current positions
	always_comb begin
		ty_prod = (YW+DHW)'(ty_pos) * (YW+DHW)'(sh_eff);
		tx_prod = (XW+DWW)'(tx_pos) * (XW+DWW)'(sw_eff);
		unique case (div_sel_q)
			2'd0: begin
				div_dividend = NW'(sh_eff);
				div_divisor  = DVW'(dh_eff);
			end
			2'd1: begin
				div_dividend = NW'(sw_eff);
				div_divisor  = DVW'(dw_eff);
			end
			2'd2: begin
				div_dividend = NW'(ty_prod);
				div_divisor  = DVW'(dh_eff);
			end
			default: begin
				div_dividend = NW'(tx_prod);
				div_divisor  = DVW'(dw_eff);
			end
		endcase
	end

	assign div_start = (state_q == ST_DIVGO);

	nnis_div #(
		.NW (NW),
		.DW (DVW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// setup sequencer, load address and target stepping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_NORM;
			div_sel_q <= '0;
			area_q    <= '0;
			frame_q   <= '0;
			load_q    <= '0;
			tx_q      <= '0;
			ty_q      <= '0;
			tc_q      <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			rx_q      <= '0;
			ry_q      <= '0;
			rx0_q     <= '0;
			ry0_q     <= '0;
			qx0_q     <= '0;
			qy0_q     <= '0;
			restart_q <= 1'b0;
		end else if (cfg_we) begin
			state_q <= ST_NORM;
		end else begin
			unique case (state_q)
				ST_NORM: begin
					restart_q <= CW'(tc_q) >= ch_eff || DWW'(tx_q) >= dw_eff ||
							DHW'(ty_q) >= dh_eff;
					area_q  <= (DWW+DHW)'(sw_eff) * (DWW+DHW)'(sh_eff);
					state_q <= ST_FRAME;
				end
				ST_FRAME: begin
					frame_q <= FW'(frame_full);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					div_sel_q <= '0;
					state_q   <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						unique case (div_sel_q)
							2'd0: begin
								qy0_q <= DHW'(div_quo);
								ry0_q <= DHW'(div_rem);
							end
							2'd1: begin
								qx0_q <= DWW'(div_quo);
								rx0_q <= DWW'(div_rem);
							end
							2'd2: begin
								sy_q <= YW'(div_quo);
								ry_q <= DHW'(div_rem);
							end
							default: begin
								sx_q <= XW'(div_quo);
								rx_q <= DWW'(div_rem);
							end
						endcase
						if (div_sel_q == 2'd3) begin
							state_q <= ST_RUN;
						end else begin
							div_sel_q <= div_sel_q + 2'd1;
							state_q   <= ST_DIVGO;
						end
					end
				end
				ST_RUN: begin
					// running raster address of the frame store
					if (load_acc) begin
						load_q <= (load_inc >= frame_q) ? '0 : AW'(load_inc);
					end
					// channel, then column, then row
					if (emit_acc) begin
						restart_q <= 1'b0;
						if (!last_ch) begin
							tc_q <= tc_pos + TCW'(1);
							tx_q <= tx_pos;
							ty_q <= ty_pos;
						end else begin
							tc_q <= '0;
							if (!last_col) begin
								tx_q <= tx_pos + XW'(1);
								ty_q <= ty_pos;
								if (xsum >= (DWW+1)'(dw_eff)) begin
									rx_q <= DWW'(xsum - (DWW+1)'(dw_eff));
									sx_q <= XW'(sx_next + (DWW+1)'(1));
								end else begin
									rx_q <= DWW'(xsum);
									sx_q <= XW'(sx_next);
								end
							end else begin
								tx_q <= '0;
								sx_q <= '0;
								rx_q <= '0;
								if (!last_row) begin
									ty_q <= ty_pos + YW'(1);
									if (ysum >= (DHW+1)'(dh_eff)) begin
										ry_q <= DHW'(ysum - (DHW+1)'(dh_eff));
										sy_q <= YW'(sy_next + (DHW+1)'(1));
									end else begin
										ry_q <= DHW'(ysum);
										sy_q <= YW'(sy_next);
									end
								end else begin
									ty_q <= '0;
									sy_q <= '0;
									ry_q <= '0;
								end
							end
						end
					end
				end
				default: state_q <= ST_NORM;
			endcase
		end
	end

	// emit pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= emit_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2 | (v_s3 & !out_load);
		end
	end

	// stage 1 capture, stage 2 row base
	assign rb_full = (YW+DWW)'(sy_s1) * (YW+DWW)'(sw_eff);

	always_ff @(posedge clk) begin
		if (emit_acc) begin
			sy_s1  <= sy_q;
			sx_s1  <= sx_q;
			tc_s1  <= tc_pos;
			end_s1 <= last_ch && last_col && last_row;
		end
		if (v_s1) begin
			rb_s2  <= PW'(rb_full);
			sx_s2  <= sx_s1;
			tc_s2  <= tc_s1;
			end_s2 <= end_s1;
		end
		if (v_s2) begin
			tc_s3  <= tc_s2;
			end_s3 <= end_s2;
		end
	end

	// byte address of the source pixel channel
	always_comb begin
		pix_s2    = PW'((PW+1)'(rb_s2) + (PW+1)'(sx_s2));
		addr_full = (PW+CW)'(pix_s2) * (PW+CW)'(ch_eff) + (PW+CW)'(tc_s2);
		rd_addr   = AW'(addr_full);
	end

	nnis_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (load_acc),
		.wr_addr (load_eff),
		.wr_data (s_tdata),
		.rd_en   (v_s2),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_q <= rd_data;
			chidx_q <= CHAN_W'(tc_s3);
			last_q  <= end_s3;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pixel_q;
	assign m_tuser  = chidx_q;
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	// an accepted emit walks through every stage in turn
	a_emit_flow: assert property (@(posedge clk) disable iff (!arst_n)
		emit_acc |=> v_s1 ##1 v_s2 ##1 v_s3)
		else $error("emit did not advance through the pipeline");

	// stepping remainders stay below their divisors
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rx_q < dw_eff) && (ry_q < dh_eff))
		else $error("stepping remainder out of range");

	// source position stays inside the source image
	a_src_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (DWW'(sx_q) < sw_eff) && (DHW'(sy_q) < sh_eff))
		else $error("source position out of range");

	// load address after a load stays inside the source frame
	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> (FW'(load_q) < frame_q))
		else $error("load address beyond frame");
`endif

endmodule
